FILE: hdl/cfo_drift_phase_rotator_top_assert.svh
// Assertion macros shared by the rotator modules.
`ifndef CFO_DRIFT_PHASE_ROTATOR_TOP_ASSERT_SVH
`define CFO_DRIFT_PHASE_ROTATOR_TOP_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked while reset is released.
`define CDPR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cdpr same-cycle check failed");
// Next-cycle implication, checked while reset is released.
`define CDPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cdpr next-cycle check failed");
`else
`define CDPR_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define CDPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: hdl/cdpr_pkg.sv
// Shared constants, types and the sine table builder for the rotator.
package cdpr_pkg;

  localparam int PHASE_BITS      = 48;
  localparam int INC_BITS        = 48;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS     = 16;
  localparam int TAB_N           = 1 << TABLE_ADDR_BITS;
  localparam int TAB_AW          = TABLE_ADDR_BITS + 1;
  localparam int TAB_BITS        = 15;
  localparam int TRIG_BITS       = 16;
  localparam int PROD_BITS       = SAMPLE_BITS + TRIG_BITS;
  localparam int SUM_BITS        = PROD_BITS + 1;
  localparam int FRAC_BITS       = 15;
  localparam int CFG_IDX_BITS    = 2;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ROTATE_ENABLE   = 2'd0,
    REG_BASE_INCREMENT  = 2'd1,
    REG_INCREMENT_DRIFT = 2'd2
  } cfg_reg_t;

  // One sample moving down the pipeline with its control bits.
  typedef struct packed {
    logic                          valid;
    logic                          bypass;
    logic [1:0]                    quad;
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
  } item_t;

  typedef logic [TAB_BITS-1:0] sin_tab_t [0:TAB_N];

  // One Horner step 1 - q*acc in Q2.30, clamped at zero.
  function automatic logic [63:0] horner_step(input logic [63:0] q, input logic [63:0] acc);
    logic [63:0] t;
    t = (q * acc) >> 30;
    return (t >= Q30_ONE) ? 64'd0 : (Q30_ONE - t);
  endfunction

  // Quarter-wave sine table in unsigned Q0.15 from a degree-13 Taylor series.
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t    tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] acc;
    for (int k = 0; k <= TAB_N; k++) begin
      x   = (HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
      x2  = (x * x) >> 30;
      acc = Q30_ONE;
      acc = horner_step(x2 / 64'd156, acc);
      acc = horner_step(x2 / 64'd110, acc);
      acc = horner_step(x2 / 64'd72, acc);
      acc = horner_step(x2 / 64'd42, acc);
      acc = horner_step(x2 / 64'd20, acc);
      acc = horner_step(x2 / 64'd6, acc);
      acc = (x * acc) >> 30;
      tab[k] = TAB_BITS'((acc * 64'd32767 + (Q30_ONE >> 1)) >> 30);
    end
    return tab;
  endfunction

endpackage

FILE: hdl/cdpr_nco.sv
// Configuration registers, phase and drift accumulators and the input stage.
`include "cfo_drift_phase_rotator_top_assert.svh"

module cdpr_nco (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    adv,
  input  logic                                    in_valid,
  input  logic signed [cdpr_pkg::SAMPLE_BITS-1:0] in_re,
  input  logic signed [cdpr_pkg::SAMPLE_BITS-1:0] in_im,
  input  logic                                    cfg_fire,
  input  logic [cdpr_pkg::CFG_IDX_BITS-1:0]       cfg_idx,
  input  logic [cdpr_pkg::INC_BITS-1:0]           cfg_value,
  output cdpr_pkg::item_t                         s1_item,
  output logic [cdpr_pkg::TABLE_ADDR_BITS-1:0]    s1_idx
);

  localparam int PB = cdpr_pkg::PHASE_BITS;

  logic          en_r;
  logic [PB-1:0] step_r;
  logic [PB-1:0] drift_r;
  logic [PB-1:0] inc_r;
  logic [PB-1:0] phase_r;
  logic [PB-1:0] phase_nxt;
  logic [PB-1:0] cfg_phase;
  logic          fire;
  logic          rotate;

  cdpr_pkg::item_t                      s1_r;
  logic [cdpr_pkg::TABLE_ADDR_BITS-1:0] idx_r;

  assign fire      = in_valid && adv;
  assign rotate    = fire && en_r;
  assign cfg_phase = PB'($signed(cfg_value));
  // The increment for this sample is applied before the lookup.
  assign phase_nxt = phase_r + inc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= 1'b0;
      step_r  <= '0;
      drift_r <= '0;
      inc_r   <= '0;
      phase_r <= '0;
    end else if (cfg_fire) begin
      case (cdpr_pkg::cfg_reg_t'(cfg_idx))
        cdpr_pkg::REG_ROTATE_ENABLE: begin
          en_r <= cfg_value[0];
        end
        cdpr_pkg::REG_BASE_INCREMENT: begin
          inc_r <= cfg_phase + drift_r;
        end
        cdpr_pkg::REG_INCREMENT_DRIFT: begin
          step_r <= cfg_phase;
        end
        default: begin
        end
      endcase
    end else if (rotate) begin
      phase_r <= phase_nxt;
      drift_r <= drift_r + step_r;
      inc_r   <= inc_r + step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (adv) begin
      s1_r.valid  <= in_valid;
      s1_r.bypass <= !en_r;
      s1_r.quad   <= phase_nxt[PB-1 -: 2];
      s1_r.re     <= in_re;
      s1_r.im     <= in_im;
      idx_r       <= phase_nxt[PB-3 -: cdpr_pkg::TABLE_ADDR_BITS];
    end
  end

  assign s1_item = s1_r;
  assign s1_idx  = idx_r;

  `CDPR_ASSERT_NEXT(a_phase_holds, clk, rst_n, !rotate, $stable(phase_r))
  `CDPR_ASSERT_NEXT(a_inc_steps, clk, rst_n, rotate && !cfg_fire,
                    inc_r == $past(inc_r) + $past(step_r))

endmodule

FILE: hdl/cdpr_sin_rom.sv
// Quarter-wave sine ROM with two registered read ports.
module cdpr_sin_rom (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  cdpr_pkg::item_t                      s1_item,
  input  logic [cdpr_pkg::TABLE_ADDR_BITS-1:0] s1_idx,
  output cdpr_pkg::item_t                      s2_item,
  output logic [cdpr_pkg::TAB_BITS-1:0]        tab_lo,
  output logic [cdpr_pkg::TAB_BITS-1:0]        tab_hi
);

  localparam int AW = cdpr_pkg::TAB_AW;
  localparam cdpr_pkg::sin_tab_t SIN_TAB = cdpr_pkg::build_sin_tab();

  logic [AW-1:0]                 addr_lo;
  logic [AW-1:0]                 addr_hi;
  logic [cdpr_pkg::TAB_BITS-1:0] lo_r;
  logic [cdpr_pkg::TAB_BITS-1:0] hi_r;
  cdpr_pkg::item_t               s2_r;

  assign addr_lo = {1'b0, s1_idx};
  assign addr_hi = AW'(cdpr_pkg::TAB_N) - addr_lo;

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_r <= SIN_TAB[addr_lo];
      hi_r <= SIN_TAB[addr_hi];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (adv) begin
      s2_r <= s1_item;
    end
  end

  assign s2_item = s2_r;
  assign tab_lo  = lo_r;
  assign tab_hi  = hi_r;

endmodule

FILE: hdl/cdpr_mixer.sv
// Quadrant fold, complex multiply, rounding, saturation or bypass copy, and output register.
`include "cfo_drift_phase_rotator_top_assert.svh"

module cdpr_mixer (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  cdpr_pkg::item_t                         s2_item,
  input  logic [cdpr_pkg::TAB_BITS-1:0]           tab_lo,
  input  logic [cdpr_pkg::TAB_BITS-1:0]           tab_hi,
  input  logic                                    out_ready,
  output logic                                    adv,
  output logic                                    out_valid,
  output logic signed [cdpr_pkg::SAMPLE_BITS-1:0] out_re,
  output logic signed [cdpr_pkg::SAMPLE_BITS-1:0] out_im
);

  localparam int SB = cdpr_pkg::SAMPLE_BITS;
  localparam int TB = cdpr_pkg::TRIG_BITS;
  localparam int PB = cdpr_pkg::PROD_BITS;
  localparam int UB = cdpr_pkg::SUM_BITS;
  localparam logic signed [UB-1:0] ROUND_BIAS = UB'(1) << (cdpr_pkg::FRAC_BITS - 1);
  localparam logic signed [UB-1:0] SAT_MAX    = UB'((1 << (SB - 1)) - 1);
  localparam logic signed [UB-1:0] SAT_MIN    = -(UB'(1) << (SB - 1));

  logic signed [TB-1:0] lo_s;
  logic signed [TB-1:0] hi_s;
  logic signed [TB-1:0] sin_v;
  logic signed [TB-1:0] cos_v;

  cdpr_pkg::item_t      s3_r;
  logic signed [PB-1:0] p_rc_r;
  logic signed [PB-1:0] p_is_r;
  logic signed [PB-1:0] p_rs_r;
  logic signed [PB-1:0] p_ic_r;

  logic signed [UB-1:0] sum_re;
  logic signed [UB-1:0] sum_im;
  logic signed [UB-1:0] shr_re;
  logic signed [UB-1:0] shr_im;

  logic                 out_valid_r;
  logic signed [SB-1:0] out_re_r;
  logic signed [SB-1:0] out_im_r;

  function automatic logic signed [SB-1:0] sat(input logic signed [UB-1:0] v);
    logic signed [UB-1:0] c;
    c = (v > SAT_MAX) ? SAT_MAX : ((v < SAT_MIN) ? SAT_MIN : v);
    return c[SB-1:0];
  endfunction

  // The whole pipeline moves when the output slot is free or being emptied.
  assign adv = !out_valid_r || out_ready;

  assign lo_s = $signed({1'b0, tab_lo});
  assign hi_s = $signed({1'b0, tab_hi});

  always_comb begin
    case (s2_item.quad)
      2'd0: begin
        sin_v = lo_s;
        cos_v = hi_s;
      end
      2'd1: begin
        sin_v = hi_s;
        cos_v = -lo_s;
      end
      2'd2: begin
        sin_v = -lo_s;
        cos_v = -hi_s;
      end
      default: begin
        sin_v = -hi_s;
        cos_v = lo_s;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else if (adv) begin
      s3_r   <= s2_item;
      p_rc_r <= s2_item.re * cos_v;
      p_is_r <= s2_item.im * sin_v;
      p_rs_r <= s2_item.re * sin_v;
      p_ic_r <= s2_item.im * cos_v;
    end
  end

  assign sum_re = UB'(p_rc_r) - UB'(p_is_r) + ROUND_BIAS;
  assign sum_im = UB'(p_rs_r) + UB'(p_ic_r) + ROUND_BIAS;
  assign shr_re = sum_re >>> cdpr_pkg::FRAC_BITS;
  assign shr_im = sum_im >>> cdpr_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_r.valid;
      out_re_r    <= s3_r.bypass ? s3_r.re : sat(shr_re);
      out_im_r    <= s3_r.bypass ? s3_r.im : sat(shr_im);
    end
  end

  assign out_valid = out_valid_r;
  assign out_re    = out_re_r;
  assign out_im    = out_im_r;

  `CDPR_ASSERT_NEXT(a_bypass_copies, clk, rst_n, adv && s3_r.valid && s3_r.bypass,
                    out_re_r == $past(s3_r.re) && out_im_r == $past(s3_r.im))
  `CDPR_ASSERT_IMPL(a_stall_blocks, clk, rst_n, out_valid_r && !out_ready, !adv)

endmodule

FILE: hdl/cfo_drift_phase_rotator_top.sv
// Top level of the carrier frequency offset rotator with linear frequency drift.
// An accepted sample moves through the stage 1, 2 and 3 registers and then the output register to out_tvalid.
// Throughput: one sample per cycle unless out_tready stalls; the four pipeline registers advance together.
// The rate is set by the single phase accumulator add and the dual-port sine ROM read.
// Reset (rst_n low, synchronous) clears the valid bits, enable, step, increment, phase and drift sum, not the data.
module cfo_drift_phase_rotator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] in_real, [31:16] in_imag
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] out_real, [31:16] out_imag
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int SB = cdpr_pkg::SAMPLE_BITS;

  // Pipeline advance; shared by every stage so samples never overtake each other.
  logic adv;

  cdpr_pkg::item_t                      s1_item;
  cdpr_pkg::item_t                      s2_item;
  logic [cdpr_pkg::TABLE_ADDR_BITS-1:0] s1_idx;
  logic [cdpr_pkg::TAB_BITS-1:0]        tab_lo;
  logic [cdpr_pkg::TAB_BITS-1:0]        tab_hi;
  logic signed [SB-1:0]                 out_re;
  logic signed [SB-1:0]                 out_im;

  // Configuration writes are always taken; the user must issue them only while idle, the block does not enforce this.
  assign cfg_ready = 1'b1;
  // A new sample is taken whenever the pipeline can move, that is while the
  // output register is empty or its result is being taken in that cycle.
  assign in_tready = adv;

  // Stage 1: phase accumulator, drift accumulator and input capture.
  cdpr_nco u_nco (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_tvalid),
    .in_re     ($signed(in_tdata[15:0])),
    .in_im     ($signed(in_tdata[31:16])),
    .cfg_fire  (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_value (cfg_data),
    .s1_item   (s1_item),
    .s1_idx    (s1_idx)
  );

  // Stage 2: registered lookup of sin and cos magnitudes.
  cdpr_sin_rom u_rom (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .s1_item (s1_item),
    .s1_idx  (s1_idx),
    .s2_item (s2_item),
    .tab_lo  (tab_lo),
    .tab_hi  (tab_hi)
  );

  // Stages 3 and 4: products, then rounding and saturation, or a bypass copy, into the output register.
  cdpr_mixer u_mixer (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_item   (s2_item),
    .tab_lo    (tab_lo),
    .tab_hi    (tab_hi),
    .out_ready (out_tready),
    .adv       (adv),
    .out_valid (out_tvalid),
    .out_re    (out_re),
    .out_im    (out_im)
  );

  assign out_tdata = {out_im, out_re};

endmodule
